// ----- sv/fnlp_pkg.sv -----
// ----------------------------------------------------------------------------
// fnlp_pkg
// Shared types, character codes and digit helpers for the number parser.
// ----------------------------------------------------------------------------
package fnlp_pkg;

   localparam int ACC_WIDTH_DEFAULT = 64;

   // base_select codes
   localparam logic [2:0] BASE_BIN = 3'd0;
   localparam logic [2:0] BASE_OCT = 3'd1;
   localparam logic [2:0] BASE_DEC = 3'd2;
   localparam logic [2:0] BASE_HEX = 3'd3;

   // character codes
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_F     = 8'h46;

   localparam logic [4:0] DIGIT_NONE = 5'd31;

   // classification of a finished token
   typedef struct packed {
      logic single_ok;
      logic double_ok;
      logic minus;
   } tok_flags_type;

   // digit value of a character, DIGIT_NONE if it is no digit
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
         return t[4:0];
      end
      if (c >= CH_A && c <= CH_F) begin
         t = c - CH_A + 8'd10;
         return t[4:0];
      end
      return DIGIT_NONE;
   endfunction

   // radix of a base code, zero for an unsupported base
   function automatic logic [4:0] radix_of(input logic [2:0] b);
      logic [4:0] r;
      unique case (b)
         BASE_BIN: r = 5'd2;
         BASE_OCT: r = 5'd8;
         BASE_DEC: r = 5'd10;
         BASE_HEX: r = 5'd16;
         default:  r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/fnlp_scan.sv -----
// ----------------------------------------------------------------------------
// fnlp_scan
// Per-character token checking and shift-add accumulation of the digits.
// ----------------------------------------------------------------------------
module fnlp_scan #(
   parameter int ACC_WIDTH = fnlp_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             base_select,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_code,
   input  logic                   req_last_of_token,
   output logic                   fin_valid,
   input  logic                   fin_ready,
   output fnlp_pkg::tok_flags_type fin_flags,
   output logic [ACC_WIDTH-1:0]   fin_acc
);
   import fnlp_pkg::*;

   logic                 at_first_ff, at_first_in;
   logic                 single_ok_ff, single_ok_in;
   logic                 double_ok_ff, double_ok_in;
   logic                 minus_ff, minus_in;
   logic [ACC_WIDTH-1:0] acc_ff, acc_in;

   logic                 accept;
   logic [4:0]           digit;
   logic [4:0]           radix;
   logic                 is_digit, is_sep, is_minus;
   logic                 ok_s, ok_d;
   logic [ACC_WIDTH-1:0] scaled;

   assign req_ready = fin_ready;
   assign accept    = req_valid && req_ready;
   assign fin_valid = req_valid && req_last_of_token;

   // classify the character against the current base
   always_comb begin
      digit    = digit_of(req_char_code);
      radix    = radix_of(base_select);
      is_digit = (radix != 5'd0) && (digit < radix);
      is_sep   = (req_char_code == CH_COMMA) || (req_char_code == CH_DOT);
      is_minus = (req_char_code == CH_MINUS);

      priority if (at_first_ff && req_last_of_token) begin
         ok_s = is_digit;
         ok_d = 1'b0;
      end else if (at_first_ff) begin
         ok_s = is_digit || is_minus;
         ok_d = ok_s;
      end else if (req_last_of_token) begin
         ok_s = is_digit;
         ok_d = (req_char_code == CH_DOT);
      end else begin
         ok_s = is_digit || is_sep;
         ok_d = ok_s;
      end
      if (radix == 5'd0) begin
         ok_s = 1'b0;
         ok_d = 1'b0;
      end
      if (base_select == BASE_BIN) begin
         ok_d = 1'b0;
      end
   end

   // multiply by the radix with shifts, and one add for decimal
   always_comb begin
      unique case (base_select)
         BASE_BIN: scaled = acc_ff << 1;
         BASE_OCT: scaled = acc_ff << 3;
         BASE_DEC: scaled = (acc_ff << 3) + (acc_ff << 1);
         BASE_HEX: scaled = acc_ff << 4;
         default:  scaled = acc_ff;
      endcase
   end

   // next token state after this character
   always_comb begin
      single_ok_in = single_ok_ff && ok_s;
      double_ok_in = double_ok_ff && ok_d;
      minus_in     = minus_ff || (at_first_ff && !req_last_of_token && is_minus);
      acc_in       = is_digit ? scaled + ACC_WIDTH'(digit) : acc_ff;
      at_first_in  = 1'b0;
   end

   assign fin_flags.single_ok = single_ok_in;
   assign fin_flags.double_ok = double_ok_in;
   assign fin_flags.minus     = minus_in;
   assign fin_acc             = acc_in;

   // advance on each transfer, clear at the end of a token
   always_ff @(posedge clock) begin
      if (reset) begin
         at_first_ff  <= 1'b1;
         single_ok_ff <= 1'b1;
         double_ok_ff <= 1'b1;
         minus_ff     <= 1'b0;
         acc_ff       <= '0;
      end else if (accept) begin
         if (req_last_of_token) begin
            at_first_ff  <= 1'b1;
            single_ok_ff <= 1'b1;
            double_ok_ff <= 1'b1;
            minus_ff     <= 1'b0;
            acc_ff       <= '0;
         end else begin
            at_first_ff  <= at_first_in;
            single_ok_ff <= single_ok_in;
            double_ok_ff <= double_ok_in;
            minus_ff     <= minus_in;
            acc_ff       <= acc_in;
         end
      end
   end

   // a finished token leaves clean state behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_of_token |=> at_first_ff && !minus_ff && acc_ff == '0)
      else $error("token state not cleared after last character");

   // a minus is only recorded off the first character
   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      accept && !at_first_ff && !minus_ff |=> !minus_ff || at_first_ff)
      else $error("minus recorded inside a token");

   // hold the token state while a character waits
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> $stable(acc_ff) && $stable(at_first_ff))
      else $error("token state changed while the character waited");

endmodule

// ----- sv/fnlp_split.sv -----
// ----------------------------------------------------------------------------
// fnlp_split
// Sign resolution and split of the token value into single and double parts.
// ----------------------------------------------------------------------------
module fnlp_split #(
   parameter int ACC_WIDTH = fnlp_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fin_valid,
   output logic                    fin_ready,
   input  fnlp_pkg::tok_flags_type fin_flags,
   input  logic [ACC_WIDTH-1:0]    fin_acc,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_single,
   output logic                    rsp_is_double,
   output logic                    rsp_not_a_number,
   output logic signed [31:0]      rsp_single_value,
   output logic signed [31:0]      rsp_double_low,
   output logic signed [31:0]      rsp_double_high
);
   import fnlp_pkg::*;

   // stage 1: signed value
   logic                 s1_valid_ff;
   tok_flags_type        s1_flags_ff;
   logic [ACC_WIDTH-1:0] s1_value_ff, s1_value_in;
   // stage 2: magnitude and sign
   logic                 s2_valid_ff;
   tok_flags_type        s2_flags_ff;
   logic                 s2_neg_ff;
   logic [ACC_WIDTH-1:0] s2_mag_ff, s2_mag_in;
   logic [31:0]          s2_low_ff;
   // stage 3: result register
   logic                 rsp_valid_ff;
   logic                 single_ff, double_ff, nan_ff;
   logic [31:0]          sv_ff, lo_ff, hi_ff;
   logic [31:0]          lo_in, hi_in;

   logic                 ready1, ready2, ready3;
   logic [ACC_WIDTH+31:0] mag_ext;
   logic [31:0]          rem, quo;

   // move a stage when the next one is free or draining
   assign ready3    = !rsp_valid_ff || rsp_ready;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign fin_ready = ready1;

   assign s1_value_in = fin_flags.minus ? ACC_WIDTH'(-fin_acc) : fin_acc;
   assign s2_mag_in   = s1_value_ff[ACC_WIDTH-1] ? ACC_WIDTH'(-s1_value_ff) : s1_value_ff;

   // remainder and quotient by 2^31, negated back for a negative value
   always_comb begin
      mag_ext = {32'd0, s2_mag_ff};
      rem     = {1'b0, s2_mag_ff[30:0]};
      quo     = mag_ext[62:31];
      lo_in   = 32'd0;
      hi_in   = 32'd0;
      if (s2_flags_ff.double_ok) begin
         lo_in = s2_neg_ff ? 32'(-rem) : rem;
         hi_in = s2_neg_ff ? 32'(-quo) : quo;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) s1_valid_ff <= fin_valid;
         if (ready2) s2_valid_ff <= s1_valid_ff;
         if (ready3) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_flags_ff <= fin_flags;
         s1_value_ff <= s1_value_in;
      end
      if (ready2) begin
         s2_flags_ff <= s1_flags_ff;
         s2_neg_ff   <= s1_value_ff[ACC_WIDTH-1];
         s2_mag_ff   <= s2_mag_in;
         s2_low_ff   <= s1_value_ff[31:0];
      end
      if (ready3) begin
         single_ff <= s2_flags_ff.single_ok;
         double_ff <= s2_flags_ff.double_ok;
         nan_ff    <= !s2_flags_ff.single_ok && !s2_flags_ff.double_ok;
         sv_ff     <= s2_flags_ff.single_ok ? s2_low_ff : 32'd0;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_single    = single_ff;
   assign rsp_is_double    = double_ff;
   assign rsp_not_a_number = nan_ff;
   assign rsp_single_value = sv_ff;
   assign rsp_double_low   = lo_ff;
   assign rsp_double_high  = hi_ff;

   // exactly one classification per result
   a_one_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({single_ff, double_ff, nan_ff}))
      else $error("result classification not one-hot");

   // double fields are zero unless the token is a double
   a_double_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !double_ff |-> lo_ff == 32'd0 && hi_ff == 32'd0)
      else $error("double fields set on a non-double result");

   // a blocked first stage keeps its value
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !ready2 |=> s1_valid_ff && $stable(s1_value_ff))
      else $error("stage 1 lost its value while blocked");

endmodule

// ----- sv/forth_number_literal_parser.sv -----
// ----------------------------------------------------------------------------
// forth_number_literal_parser
// Classifies a token of characters as a single or double number and converts it.
// ----------------------------------------------------------------------------
// Feed one character per transfer, flagging the last one of each token. A new
// character is taken every cycle while the result path is not stalled; the
// digit accumulator does one shift-add by the radix per character. Each token
// produces one result, which passes through three registers in turn: the
// signed value, then the magnitude and sign, then the result register.
// These three registers hold up to three results. Once they are all full and
// the result side holds off, every character waits, not only the last one of
// a token.
// The base register (csr_data: 0 binary, 1 octal, 2 decimal, 3 hex, others
// reject every token) resets to decimal and should be written between tokens.
// ----------------------------------------------------------------------------
module forth_number_literal_parser #(
   parameter int ACC_WIDTH = fnlp_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_of_token,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_single,
   output logic               rsp_is_double,
   output logic               rsp_not_a_number,
   output logic signed [31:0] rsp_single_value,
   output logic signed [31:0] rsp_double_low,
   output logic signed [31:0] rsp_double_high
);
   import fnlp_pkg::*;

   logic                 base_write;
   logic [2:0]           base_select_ff;
   logic                 fin_valid, fin_ready;
   tok_flags_type        fin_flags;
   logic [ACC_WIDTH-1:0] fin_acc;

   // base register, always writable
   assign csr_ready  = 1'b1;
   assign base_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_select_ff <= BASE_DEC;
      end else if (base_write) begin
         base_select_ff <= csr_data;
      end
   end

   fnlp_scan #(.ACC_WIDTH(ACC_WIDTH)) u_scan (
      .clock             (clock),
      .reset             (reset),
      .base_select       (base_select_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_last_of_token (req_last_of_token),
      .fin_valid         (fin_valid),
      .fin_ready         (fin_ready),
      .fin_flags         (fin_flags),
      .fin_acc           (fin_acc)
   );

   fnlp_split #(.ACC_WIDTH(ACC_WIDTH)) u_split (
      .clock            (clock),
      .reset            (reset),
      .fin_valid        (fin_valid),
      .fin_ready        (fin_ready),
      .fin_flags        (fin_flags),
      .fin_acc          (fin_acc),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_single    (rsp_is_single),
      .rsp_is_double    (rsp_is_double),
      .rsp_not_a_number (rsp_not_a_number),
      .rsp_single_value (rsp_single_value),
      .rsp_double_low   (rsp_double_low),
      .rsp_double_high  (rsp_double_high)
   );

endmodule
